// ===== rtl/flow_id_route_table_core_defines.svh =====
`ifndef FLOW_ID_ROUTE_TABLE_CORE_DEFINES_SVH
`define FLOW_ID_ROUTE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FRT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define FRT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/frt_pkg.sv =====
`default_nettype none

package frt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int DEFAULT_ADDR_BITS   = 16;
    localparam int FIELD_ADDR_W        = 16;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 16;

    localparam logic [7:0] RETRANSMIT_RESET = 8'd10;

    localparam logic [1:0] OP_ADD        = 2'd0;
    localparam logic [1:0] OP_SET_ONLINE = 2'd1;
    localparam logic [1:0] OP_REMOVE     = 2'd2;
    localparam logic [1:0] OP_LOOKUP     = 2'd3;

    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_UPDATED   = 3'd1;
    localparam logic [2:0] STAT_UNCHANGED = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;
    localparam logic [2:0] STAT_REMOVED   = 3'd5;
    localparam logic [2:0] STAT_ACK       = 3'd6;
    localparam logic [2:0] STAT_MISMATCH  = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELIABLE_MODE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRANSMIT_TIME = 2'd2;

    localparam logic [2:0] MARK_UPD = 3'b001;
    localparam logic [2:0] MARK_CHG = 3'b010;
    localparam logic [2:0] MARK_ONL = 3'b100;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] source_addr;
        logic [15:0] flow_id;
        logic [15:0] hop_addr;
        logic [7:0]  action_code;
        logic [15:0] path_weight;
        logic [7:0]  hop_count;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [15:0] out_next_hop;
        logic [7:0]  out_action;
        logic [15:0] out_weight;
        logic [7:0]  out_hops;
        logic        out_updated_flag;
        logic        out_changed;
        logic        out_online;
        logic [7:0]  out_countdown;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMP,
        ST_COMMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/frt_ctrl.sv =====
`default_nettype none

module frt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire frt_pkg::dp_status_t dp_status,
    output frt_pkg::ctrl_cmd_t     cmd
);
    import frt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (dp_status.scan_last)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!dp_status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_COMP:
            begin
                cmd = '0;
            end
            ST_COMMIT:
            begin
                cmd.commit = !dp_status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/frt_datapath.sv =====
`default_nettype none

module frt_datapath #(
    parameter int TABLE_DEPTH = frt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDR_BITS   = frt_pkg::DEFAULT_ADDR_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire frt_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output frt_pkg::out_item_t                   out_data,
    input  wire logic                            cfg_we,
    input  wire logic [frt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [frt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire frt_pkg::ctrl_cmd_t              cmd,
    output frt_pkg::dp_status_t                  dp_status
);
    import frt_pkg::*;

    localparam int AW = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic [AW-1:0] source;
        logic [15:0]   flow;
        logic [AW-1:0] hop_addr;
        logic [7:0]    action;
        logic [15:0]   weight;
        logic [7:0]    hops;
        logic [2:0]    marks;
        logic [7:0]    countdown;
    } entry_t;

    entry_t mem [TABLE_DEPTH];

    logic [15:0]            own_addr_reg;
    logic                   reliable_reg;
    logic [7:0]             retx_time_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [IW-1:0]          cnt_reg;
    logic                   rd_pend_reg;
    logic [IW-1:0]          rd_idx_reg;
    logic                   hit_found_reg;
    logic                   free_found_reg;
    logic                   any_rm_reg;
    logic                   out_valid_reg;
    in_item_t               item_reg;
    entry_t                 rd_data_reg;
    entry_t                 hit_entry_reg;
    logic [IW-1:0]          hit_idx_reg;
    logic [IW-1:0]          free_idx_reg;
    out_item_t              out_data_reg;

    logic [AW-1:0] key_src;
    logic [AW-1:0] key_nh;
    logic          cmp_valid;
    logic          cmp_key;
    logic          cmp_src;
    logic          own_match;
    logic          differs;
    logic          show;
    logic          wr_en;
    logic          set_valid;
    logic [IW-1:0] wr_idx;
    logic [2:0]    res_status;
    entry_t        ent;
    out_item_t     res;

    assign key_src   = item_reg.source_addr[AW-1:0];
    assign key_nh    = item_reg.hop_addr[AW-1:0];
    assign cmp_valid = rd_pend_reg && valid_reg[rd_idx_reg];
    assign cmp_src   = cmp_valid && (rd_data_reg.source == key_src);
    assign cmp_key   = cmp_src && (rd_data_reg.flow == item_reg.flow_id);
    assign own_match = (key_src == own_addr_reg[AW-1:0]);
    assign differs   = (hit_entry_reg.hop_addr != key_nh)
                    || (hit_entry_reg.action != item_reg.action_code);

    assign dp_status.scan_last = (cnt_reg == LAST_IDX);
    assign dp_status.out_busy  = out_valid_reg && out_stall;
    assign out_valid           = out_valid_reg;
    assign out_data            = out_data_reg;

    always_comb
    begin
        ent        = hit_entry_reg;
        show       = 1'b0;
        wr_en      = 1'b0;
        set_valid  = 1'b0;
        wr_idx     = hit_idx_reg;
        res_status = STAT_NOT_FOUND;
        case (item_reg.operation)
            OP_ADD:
            begin
                if (hit_found_reg || free_found_reg)
                begin
                    if (hit_found_reg)
                    begin
                        if (differs)
                        begin
                            ent.hop_addr = key_nh;
                            ent.action   = item_reg.action_code;
                            ent.marks    = ent.marks | MARK_UPD | MARK_CHG;
                            res_status   = STAT_UPDATED;
                        end
                        else
                        begin
                            res_status = STAT_UNCHANGED;
                        end
                    end
                    else
                    begin
                        ent.source   = key_src;
                        ent.flow     = item_reg.flow_id;
                        ent.hop_addr = key_nh;
                        ent.action   = item_reg.action_code;
                        ent.marks    = MARK_CHG;
                        wr_idx       = free_idx_reg;
                        set_valid    = 1'b1;
                        res_status   = STAT_INSERTED;
                    end
                    if (!hit_found_reg || differs)
                    begin
                        if (reliable_reg)
                        begin
                            ent.marks     = ent.marks & ~MARK_ONL;
                            ent.countdown = retx_time_reg;
                        end
                        else
                        begin
                            ent.marks     = ent.marks | MARK_ONL;
                            ent.countdown = 8'd0;
                        end
                    end
                    ent.weight = item_reg.path_weight;
                    ent.hops   = item_reg.hop_count;
                    if (own_match)
                    begin
                        ent.marks = ent.marks | MARK_ONL;
                    end
                    wr_en = 1'b1;
                    show  = 1'b1;
                end
                else
                begin
                    res_status = STAT_FULL;
                end
            end
            OP_SET_ONLINE:
            begin
                if (hit_found_reg)
                begin
                    show = 1'b1;
                    if (!differs)
                    begin
                        ent.marks  = ent.marks | MARK_ONL;
                        wr_en      = 1'b1;
                        res_status = STAT_ACK;
                    end
                    else
                    begin
                        res_status = STAT_MISMATCH;
                    end
                end
            end
            OP_REMOVE:
            begin
                res_status = any_rm_reg ? STAT_REMOVED : STAT_NOT_FOUND;
            end
            OP_LOOKUP:
            begin
                if (hit_found_reg)
                begin
                    show       = 1'b1;
                    res_status = STAT_UNCHANGED;
                end
            end
            default:
            begin
                res_status = STAT_NOT_FOUND;
            end
        endcase

        res        = '0;
        res.status = res_status;
        if (show)
        begin
            res.hit              = 1'b1;
            res.out_next_hop     = 16'(ent.hop_addr);
            res.out_action       = ent.action;
            res.out_weight       = ent.weight;
            res.out_hops         = ent.hops;
            res.out_updated_flag = ent.marks[0];
            res.out_changed      = ent.marks[1];
            res.out_online       = ent.marks[2];
            res.out_countdown    = ent.countdown;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            mem[wr_idx] <= ent;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[cnt_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg   <= '0;
            reliable_reg   <= 1'b0;
            retx_time_reg  <= RETRANSMIT_RESET;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            any_rm_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OWN_ADDRESS:     own_addr_reg  <= cfg_wdata;
                    CFG_RELIABLE_MODE:   reliable_reg  <= cfg_wdata[0];
                    CFG_RETRANSMIT_TIME: retx_time_reg <= cfg_wdata[7:0];
                    default:             own_addr_reg  <= own_addr_reg;
                endcase
            end

            rd_pend_reg <= cmd.scan;
            if (cmd.scan)
            begin
                rd_idx_reg <= cnt_reg;
                cnt_reg    <= cnt_reg + 1'b1;
            end

            if (cmd.start)
            begin
                cnt_reg        <= '0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                any_rm_reg     <= 1'b0;
            end
            else
            begin
                if (cmp_key)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (rd_pend_reg && !valid_reg[rd_idx_reg])
                begin
                    free_found_reg <= 1'b1;
                end
                if (cmp_src && (item_reg.operation == OP_REMOVE))
                begin
                    valid_reg[rd_idx_reg] <= 1'b0;
                    any_rm_reg            <= 1'b1;
                end
            end

            if (cmd.commit && set_valid)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            item_reg <= in_data;
        end
        if (!cmd.start && cmp_key && !hit_found_reg)
        begin
            hit_entry_reg <= rd_data_reg;
            hit_idx_reg   <= rd_idx_reg;
        end
        if (!cmd.start && rd_pend_reg && !valid_reg[rd_idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit)
        begin
            out_data_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/flow_id_route_table_core.sv =====
// An item goes through scan, compare and commit; commit registers the result beat.
// The table memory has one read port, so the key search walks one entry per cycle.
// No new item is taken until the last one commits, later if the result is held.
// Reset clears all entry valid bits and loads the configuration reset values;
// the table is usable in the first cycle after reset with no clearing pass.
`default_nettype none

module flow_id_route_table_core #(
    parameter int TABLE_DEPTH = frt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDR_BITS   = frt_pkg::DEFAULT_ADDR_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire frt_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output frt_pkg::out_item_t                   out_data,
    input  wire logic                            cfg_we,
    input  wire logic [frt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [frt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import frt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    frt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    frt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .dp_status (dp_status)
    );

endmodule

`default_nettype wire

// ===== rtl/frt_checker.sv =====
`default_nettype none
`include "flow_id_route_table_core_defines.svh"

module frt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire frt_pkg::out_item_t out_data
);
    import frt_pkg::*;

    `FRT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid,
        "result beat dropped while stalled")
    `FRT_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "new beat accepted while an item is in flight")
    `FRT_ASSERT_IMP(a_miss_zero, out_valid && !out_data.hit,
        (out_data.out_next_hop == 16'd0) && (out_data.out_weight == 16'd0)
        && (out_data.out_action == 8'd0) && (out_data.out_hops == 8'd0)
        && (out_data.out_countdown == 8'd0) && !out_data.out_online
        && !out_data.out_changed && !out_data.out_updated_flag,
        "miss result carries nonzero entry fields")
    `FRT_ASSERT_IMP(a_nohit_status, out_valid && (out_data.status == STAT_FULL
        || out_data.status == STAT_NOT_FOUND || out_data.status == STAT_REMOVED),
        !out_data.hit, "hit set with a no-entry status")

endmodule

bind flow_id_route_table_core frt_checker u_frt_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import frt_pkg::*;

    localparam int ROUTE_SLOTS = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 25;
    localparam int RX_HOLD_CYCLES = 400;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    flow_id_route_table_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the route table and its registers.
    logic        tbl_valid [ROUTE_SLOTS];
    logic [15:0] tbl_src   [ROUTE_SLOTS];
    logic [15:0] tbl_flow  [ROUTE_SLOTS];
    logic [15:0] tbl_nh    [ROUTE_SLOTS];
    logic [7:0]  tbl_act   [ROUTE_SLOTS];
    logic [15:0] tbl_wgt   [ROUTE_SLOTS];
    logic [7:0]  tbl_hops  [ROUTE_SLOTS];
    logic [2:0]  tbl_marks [ROUTE_SLOTS];
    logic [7:0]  tbl_cd    [ROUTE_SLOTS];
    logic [15:0] own_addr_q = 16'd0;
    logic        rel_mode_q = 1'b0;
    logic [7:0]  retx_time_q = RETRANSMIT_RESET;

    in_item_t  route_items_pending [$];
    out_item_t route_results_due [$];
    out_item_t oldest_result;

    logic [15:0] src_pool  [6];
    logic [15:0] flow_pool [4];
    logic [15:0] pair_nh   [2];
    logic [7:0]  pair_act  [2];

    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic rx_hold_go = 1'b0;
    int   rx_hold_left = 0;
    int   rx_stall_left = 0;
    int   tx_gap_left = 0;
    int   mismatches = 0;
    int   cycle_count = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic out_item_t route_entry_view(logic [2:0] st, int slot);
        out_item_t r;
        r = '0;
        r.status = st;
        if (slot >= 0)
        begin
            r.hit              = 1'b1;
            r.out_next_hop     = tbl_nh[slot];
            r.out_action       = tbl_act[slot];
            r.out_weight       = tbl_wgt[slot];
            r.out_hops         = tbl_hops[slot];
            r.out_updated_flag = |(tbl_marks[slot] & MARK_UPD);
            r.out_changed      = |(tbl_marks[slot] & MARK_CHG);
            r.out_online       = |(tbl_marks[slot] & MARK_ONL);
            r.out_countdown    = tbl_cd[slot];
        end
        return r;
    endfunction

    function automatic void route_set_pending(int slot);
        if (rel_mode_q)
        begin
            tbl_marks[slot] = tbl_marks[slot] & ~MARK_ONL;
            tbl_cd[slot]    = retx_time_q;
        end
        else
        begin
            tbl_marks[slot] = tbl_marks[slot] | MARK_ONL;
            tbl_cd[slot]    = 8'd0;
        end
    endfunction

    function automatic out_item_t route_table_apply(in_item_t item);
        int         slot;
        int         spare;
        logic       any_gone;
        logic [2:0] st;
        out_item_t  res;
        slot = -1;
        spare = -1;
        any_gone = 1'b0;
        for (int k = 0; k < ROUTE_SLOTS; k++)
        begin
            if (slot < 0 && tbl_valid[k] && tbl_src[k] == item.source_addr
                && tbl_flow[k] == item.flow_id)
                slot = k;
            if (spare < 0 && !tbl_valid[k])
                spare = k;
        end
        case (item.operation)
            OP_ADD:
            begin
                if (slot < 0 && spare < 0)
                    res = route_entry_view(STAT_FULL, -1);
                else
                begin
                    if (slot < 0)
                    begin
                        slot = spare;
                        tbl_valid[slot] = 1'b1;
                        tbl_src[slot]   = item.source_addr;
                        tbl_flow[slot]  = item.flow_id;
                        tbl_nh[slot]    = item.hop_addr;
                        tbl_act[slot]   = item.action_code;
                        tbl_marks[slot] = MARK_CHG;
                        route_set_pending(slot);
                        st = STAT_INSERTED;
                    end
                    else if (tbl_nh[slot] != item.hop_addr || tbl_act[slot] != item.action_code)
                    begin
                        tbl_nh[slot]    = item.hop_addr;
                        tbl_act[slot]   = item.action_code;
                        tbl_marks[slot] = tbl_marks[slot] | MARK_UPD | MARK_CHG;
                        route_set_pending(slot);
                        st = STAT_UPDATED;
                    end
                    else
                        st = STAT_UNCHANGED;
                    tbl_wgt[slot]  = item.path_weight;
                    tbl_hops[slot] = item.hop_count;
                    if (item.source_addr == own_addr_q)
                        tbl_marks[slot] = tbl_marks[slot] | MARK_ONL;
                    res = route_entry_view(st, slot);
                end
            end
            OP_SET_ONLINE:
            begin
                if (slot < 0)
                    res = route_entry_view(STAT_NOT_FOUND, -1);
                else if (tbl_nh[slot] == item.hop_addr && tbl_act[slot] == item.action_code)
                begin
                    tbl_marks[slot] = tbl_marks[slot] | MARK_ONL;
                    res = route_entry_view(STAT_ACK, slot);
                end
                else
                    res = route_entry_view(STAT_MISMATCH, slot);
            end
            OP_REMOVE:
            begin
                for (int k = 0; k < ROUTE_SLOTS; k++)
                begin
                    if (tbl_valid[k] && tbl_src[k] == item.source_addr)
                    begin
                        tbl_valid[k] = 1'b0;
                        any_gone = 1'b1;
                    end
                end
                res = route_entry_view(any_gone ? STAT_REMOVED : STAT_NOT_FOUND, -1);
            end
            default:
                res = route_entry_view(slot < 0 ? STAT_NOT_FOUND : STAT_UNCHANGED, slot);
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    function automatic in_item_t route_item(logic [1:0] op, logic [15:0] src, logic [15:0] flow,
                                            logic [15:0] nh, logic [7:0] act,
                                            logic [15:0] wgt, logic [7:0] hops);
        in_item_t item;
        item.operation   = op;
        item.source_addr = src;
        item.flow_id     = flow;
        item.hop_addr    = nh;
        item.action_code = act;
        item.path_weight = wgt;
        item.hop_count   = hops;
        return item;
    endfunction

    function automatic in_item_t make_route_item();
        in_item_t item;
        int       r;
        int       p;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 1);
        if (r < 45)
            item.operation = OP_ADD;
        else if (r < 65)
            item.operation = OP_SET_ONLINE;
        else if (r < 73)
            item.operation = OP_REMOVE;
        else
            item.operation = OP_LOOKUP;
        item.source_addr = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                       : src_pool[$urandom_range(0, 5)];
        item.flow_id = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : flow_pool[$urandom_range(0, 3)];
        item.hop_addr    = ($urandom_range(0, 4) == 0) ? 16'($urandom) : pair_nh[p];
        item.action_code = ($urandom_range(0, 4) == 0) ? 8'($urandom) : pair_act[p];
        item.path_weight = 16'($urandom);
        item.hop_count   = 8'($urandom);
        return item;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
        logic [15:0] data;
        data = val;
        if (idx == CFG_RELIABLE_MODE)
            data[15:1] = 15'($urandom);
        else if (idx == CFG_RETRANSMIT_TIME)
            data[15:8] = 8'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_OWN_ADDRESS:   own_addr_q = data;
            CFG_RELIABLE_MODE: rel_mode_q = data[0];
            default:           retx_time_q = data[7:0];
        endcase
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (route_items_pending.size() != 0 || in_valid || route_results_due.size() != 0);
    endtask

    task automatic run_phase(logic [15:0] own, logic rel, logic [7:0] retx,
                             logic tx_on, logic rx_on, logic hold, int count);
        settle();
        write_reg(CFG_OWN_ADDRESS, own);
        write_reg(CFG_RELIABLE_MODE, {15'd0, rel});
        write_reg(CFG_RETRANSMIT_TIME, {8'd0, retx});
        @(negedge clk);
        src_pool[0]  = own_addr_q;
        src_pool[1]  = 16'h0000;
        src_pool[2]  = 16'hFFFF;
        src_pool[3]  = 16'($urandom);
        src_pool[4]  = 16'($urandom);
        src_pool[5]  = 16'($urandom);
        flow_pool[0] = 16'h0000;
        flow_pool[1] = 16'hFFFF;
        flow_pool[2] = 16'($urandom);
        flow_pool[3] = 16'($urandom);
        for (int k = 0; k < 2; k++)
        begin
            pair_nh[k]  = 16'($urandom);
            pair_act[k] = 8'($urandom);
        end
        tx_idle_on = tx_on;
        rx_idle_on = rx_on;
        rx_hold_go = hold;
        for (int k = 0; k < count; k++)
            route_items_pending.push_back(make_route_item());
        @(negedge clk);
        rx_hold_go = 1'b0;
    endtask

    initial
    begin
        for (int k = 0; k < ROUTE_SLOTS; k++)
            tbl_valid[k] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        route_items_pending.push_back(route_item(OP_LOOKUP, 16'h0000, 16'h0000, 16'h0, 8'h0,
                                                 16'h0, 8'h0));
        route_items_pending.push_back(route_item(OP_SET_ONLINE, 16'h0000, 16'h0000, 16'h0, 8'h0,
                                                 16'h0, 8'h0));
        route_items_pending.push_back(route_item(OP_REMOVE, 16'h0000, 16'h0, 16'h0, 8'h0,
                                                 16'h0, 8'h0));
        route_items_pending.push_back(route_item(OP_ADD, 16'h0000, 16'h0000, 16'h0000, 8'h00,
                                                 16'h0000, 8'h00));
        route_items_pending.push_back(route_item(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                                                 16'hFFFF, 8'hFF));
        route_items_pending.push_back(route_item(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                                                 16'h1234, 8'h56));
        route_items_pending.push_back(route_item(OP_ADD, 16'hFFFF, 16'hFFFF, 16'h5A5A, 8'hFF,
                                                 16'h0001, 8'h02));
        route_items_pending.push_back(route_item(OP_SET_ONLINE, 16'hFFFF, 16'hFFFF, 16'h5A5A,
                                                 8'h3C, 16'h0, 8'h0));
        route_items_pending.push_back(route_item(OP_SET_ONLINE, 16'hFFFF, 16'hFFFF, 16'h5A5A,
                                                 8'hFF, 16'h0, 8'h0));
        for (int k = 1; k <= 15; k++)
            route_items_pending.push_back(route_item(OP_ADD, 16'h00A5, 16'(k), 16'($urandom),
                                                     8'($urandom), 16'($urandom),
                                                     8'($urandom)));
        route_items_pending.push_back(route_item(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0, 8'h0,
                                                 16'h0, 8'h0));
        route_items_pending.push_back(route_item(OP_REMOVE, 16'h00A5, 16'h0, 16'h0, 8'h0,
                                                 16'h0, 8'h0));

        run_phase(16'hFFFF, 1'b1, 8'd255, 1'b1, 1'b1, 1'b0, 90);
        run_phase(16'($urandom), 1'b1, 8'd0, 1'b0, 1'b1, 1'b1, 90);
        run_phase(16'h0000, 1'b0, 8'($urandom), 1'b0, 1'b0, 1'b0, 90);
        run_phase(16'($urandom), 1'b1, 8'($urandom), 1'b1, 1'b0, 1'b0, 90);
        run_phase(16'($urandom), 1'b0, RETRANSMIT_RESET, 1'b1, 1'b1, 1'b0, 90);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                route_results_due.push_back(route_table_apply(in_data));
            if (!in_valid || !in_stall)
            begin
                if (tx_gap_left > 0)
                begin
                    tx_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (route_items_pending.size() > 0)
                begin
                    in_data  <= route_items_pending.pop_front();
                    in_valid <= 1'b1;
                    if (tx_idle_on && $urandom_range(0, 1) == 0)
                        tx_gap_left = gap_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold_go)
            rx_hold_left <= RX_HOLD_CYCLES;
        else if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (route_results_due.size() == 0)
                begin
                    $error("result beat with no expected result waiting");
                    mismatches++;
                end
                else
                begin
                    oldest_result = route_results_due.pop_front();
                    check_field("status", oldest_result.status, out_data.status);
                    check_field("hit", oldest_result.hit, out_data.hit);
                    check_field("out_next_hop", oldest_result.out_next_hop, out_data.out_next_hop);
                    check_field("out_action", oldest_result.out_action, out_data.out_action);
                    check_field("out_weight", oldest_result.out_weight, out_data.out_weight);
                    check_field("out_hops", oldest_result.out_hops, out_data.out_hops);
                    check_field("out_updated_flag", oldest_result.out_updated_flag,
                                out_data.out_updated_flag);
                    check_field("out_changed", oldest_result.out_changed, out_data.out_changed);
                    check_field("out_online", oldest_result.out_online, out_data.out_online);
                    check_field("out_countdown", oldest_result.out_countdown,
                                out_data.out_countdown);
                end
            end
            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 9) == 0)
            begin
                rx_stall_left = gap_len() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= (rx_hold_left > 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/frt_pkg.sv
rtl/frt_ctrl.sv
rtl/frt_datapath.sv
rtl/flow_id_route_table_core.sv
rtl/frt_checker.sv
dv/tb.sv
